>>> src/ogcb_pkg.sv
// package for the order gateway circuit breaker
// word types, status, op, circuit, gateway and csr codes; no dependencies
package ogcb_pkg;

   localparam logic [1:0] OP_SUBMIT = 2'd0;
   localparam logic [1:0] OP_ACK    = 2'd1;
   localparam logic [1:0] OP_GW     = 2'd2;
   localparam logic [1:0] OP_HALT   = 2'd3;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_DUP       = 3'd1;
   localparam logic [2:0] ST_OPEN      = 3'd2;
   localparam logic [2:0] ST_BUSY      = 3'd3;
   localparam logic [2:0] ST_GW_DOWN   = 3'd4;
   localparam logic [2:0] ST_RISK      = 3'd5;
   localparam logic [2:0] ST_FULL      = 3'd6;
   localparam logic [2:0] ST_UNMATCHED = 3'd7;

   localparam logic [1:0] CIRC_CLOSED = 2'd0;
   localparam logic [1:0] CIRC_OPEN   = 2'd1;
   localparam logic [1:0] CIRC_HALF   = 2'd2;

   localparam logic [1:0] GW_READY     = 2'd0;
   localparam logic [1:0] GW_HALTED    = 2'd1;
   localparam logic [1:0] GW_UNCERTAIN = 2'd2;

   localparam logic CSR_THRESHOLD = 1'b0;
   localparam logic CSR_COOLDOWN  = 1'b1;

   typedef struct packed {
      logic [1:0]         op;
      logic [63:0]        corr_id;
      logic [63:0]        venue_id_in;
      logic signed [63:0] price;
      logic [63:0]        quantity;
      logic [63:0]        now_ns;
      logic               risk_approved;
      logic [1:0]         new_gateway_state;
      logic               halt_flag;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [63:0]        venue_ref;
      logic [63:0]        echo_correlation;
      logic signed [63:0] echo_price;
      logic [63:0]        echo_quantity;
      logic [63:0]        timestamp;
      logic [1:0]         circuit_now;
      logic [1:0]         gateway_now;
   } rsp_type;

endpackage

>>> src/ogcb_ram.sv
// generic single-port ram with registered read
// no dependencies
module ogcb_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic [WIDTH-1:0]                             wr_data,
   output logic [WIDTH-1:0]                             rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end
endmodule

>>> src/order_gateway_circuit_breaker.sv
// top level of the order gateway circuit breaker
// uses ogcb_pkg and ogcb_ram (correlation and venue tables)
//
// One word at a time. A submit or acknowledge scans the in-flight table one
// entry per cycle through a single read port on the correlation/venue
// memories, then passes through S_CHECK and S_DECIDE before S_DONE sets the
// result; an accepted submit also passes through S_WRITE, which writes the
// new entry. Gateway and halt writes go straight to S_DONE. req_ready is
// high only when the block is idle and no result is waiting; the result
// sits in an output register until taken, and the next word is taken the
// cycle after that at the earliest.
// The table's valid bits clear at reset; no clearing pass is needed.
module order_gateway_circuit_breaker #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ogcb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ogcb_pkg::rsp_type rsp_data,
   input  logic             csr_write,
   input  logic             csr_index,
   input  logic [63:0]      csr_data
);
   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_CHECK, S_DECIDE, S_WRITE, S_DONE
   } state_type;

   state_type state_ff;
   ogcb_pkg::req_type req_ff;
   ogcb_pkg::rsp_type rsp_ff;

   logic [15:0] threshold_ff;
   logic [63:0] cooldown_ff;
   logic [1:0]  circuit_ff;
   logic [15:0] fail_ff;
   logic [63:0] opened_ff;
   logic        probe_ff;
   logic [1:0]  gw_ff;
   logic        halted_ff;
   logic [63:0] next_vid_ff;
   logic [TABLE_DEPTH-1:0] valid_ff;

   // scan state
   logic [CW-1:0] idx_ff;       // entry whose read is in flight
   logic          hit_ff;
   logic [AW-1:0] hit_idx_ff;
   logic          vmatch_ff;
   logic          free_ff;
   logic [AW-1:0] free_idx_ff;
   logic          cool_ok_ff;   // elapsed time >= cooldown

   // memories
   logic          mem_we;
   logic [AW-1:0] mem_addr;
   logic [63:0]   corr_rd, venue_rd;

   ogcb_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_corr (
      .clock(clock), .wr_en(mem_we), .addr(mem_addr),
      .wr_data(req_ff.corr_id), .rd_data(corr_rd));
   ogcb_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_venue (
      .clock(clock), .wr_en(mem_we), .addr(mem_addr),
      .wr_data(next_vid_ff), .rd_data(venue_rd));

   // idle reads entry 0 so the scan has it on its first cycle
   assign mem_we = (state_ff == S_WRITE);
   assign mem_addr = (state_ff == S_WRITE) ? free_idx_ff :
                     (state_ff == S_IDLE)  ? '0 : idx_ff[AW-1:0];

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid;
   assign rsp_data = rsp_ff;

   // entry read last cycle sits at idx_ff - 1
   logic [CW-1:0] prev_idx;
   logic [AW-1:0] prev_a;
   assign prev_idx = idx_ff - CW'(1);
   assign prev_a = prev_idx[AW-1:0];

   // failure update helper values
   logic [15:0] fail_inc;
   assign fail_inc = (fail_ff == 16'hFFFF) ? fail_ff : fail_ff + 16'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid <= 1'b0;
         threshold_ff <= 16'd5;
         cooldown_ff <= 64'd30000000000;
         circuit_ff <= ogcb_pkg::CIRC_CLOSED;
         fail_ff <= '0;
         opened_ff <= '0;
         probe_ff <= 1'b0;
         gw_ff <= ogcb_pkg::GW_READY;
         halted_ff <= 1'b0;
         next_vid_ff <= 64'd1;
         valid_ff <= '0;
         idx_ff <= '0;
      end else begin
         if (csr_write) begin
            if (csr_index == ogcb_pkg::CSR_THRESHOLD) threshold_ff <= csr_data[15:0];
            else cooldown_ff <= csr_data;
         end
         if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_valid && req_ready) begin
                  req_ff <= req_data;
                  idx_ff <= CW'(1);
                  hit_ff <= 1'b0;
                  vmatch_ff <= 1'b0;
                  free_ff <= 1'b0;
                  free_idx_ff <= '0;
                  rsp_ff.status <= ogcb_pkg::ST_OK;
                  rsp_ff.venue_ref <= '0;
                  rsp_ff.echo_price <= '0;
                  rsp_ff.echo_quantity <= '0;
                  rsp_ff.timestamp <= req_data.now_ns;
                  if (req_data.op == ogcb_pkg::OP_SUBMIT ||
                      req_data.op == ogcb_pkg::OP_ACK) begin
                     rsp_ff.echo_correlation <= req_data.corr_id;
                     state_ff <= S_READ;
                  end else begin
                     rsp_ff.echo_correlation <= '0;
                     state_ff <= S_DONE;
                  end
               end
            end
            S_READ: begin
               // one entry compared per cycle
               if (valid_ff[prev_a] && corr_rd == req_ff.corr_id && !hit_ff) begin
                  hit_ff <= 1'b1;
                  hit_idx_ff <= prev_a;
                  vmatch_ff <= (venue_rd == req_ff.venue_id_in);
               end
               if (!valid_ff[prev_a] && !free_ff) begin
                  free_ff <= 1'b1;
                  free_idx_ff <= prev_a;
               end
               if (prev_idx == CW'(TABLE_DEPTH - 1)) state_ff <= S_CHECK;
               else idx_ff <= idx_ff + CW'(1);
            end
            S_CHECK: begin
               cool_ok_ff <= (req_ff.now_ns - opened_ff) >= cooldown_ff;
               state_ff <= S_DECIDE;
            end
            S_DECIDE: begin
               state_ff <= S_DONE;
               if (req_ff.op == ogcb_pkg::OP_ACK) begin
                  if (!hit_ff || !vmatch_ff || req_ff.corr_id == '0) begin
                     rsp_ff.status <= ogcb_pkg::ST_UNMATCHED;
                     gw_ff <= ogcb_pkg::GW_UNCERTAIN;
                     fail_ff <= fail_inc;
                     if (fail_inc >= threshold_ff) begin
                        circuit_ff <= ogcb_pkg::CIRC_OPEN;
                        opened_ff <= req_ff.now_ns;
                     end
                  end else begin
                     valid_ff[hit_idx_ff] <= 1'b0;
                     if (circuit_ff == ogcb_pkg::CIRC_HALF) begin
                        circuit_ff <= ogcb_pkg::CIRC_CLOSED;
                        fail_ff <= '0;
                        opened_ff <= '0;
                        probe_ff <= 1'b0;
                     end
                  end
               end else begin : submit
                  logic [1:0] circ;
                  circ = circuit_ff;
                  if (req_ff.corr_id == '0 || hit_ff) begin
                     rsp_ff.status <= ogcb_pkg::ST_DUP;
                  end else if (circ == ogcb_pkg::CIRC_OPEN && !cool_ok_ff) begin
                     rsp_ff.status <= ogcb_pkg::ST_OPEN;
                  end else begin
                     if (circ == ogcb_pkg::CIRC_OPEN) circ = ogcb_pkg::CIRC_HALF;
                     if (circ == ogcb_pkg::CIRC_HALF && probe_ff) begin
                        rsp_ff.status <= ogcb_pkg::ST_BUSY;
                     end else if (halted_ff || gw_ff != ogcb_pkg::GW_READY ||
                                  !req_ff.risk_approved) begin
                        rsp_ff.status <= (halted_ff || gw_ff != ogcb_pkg::GW_READY) ?
                                         ogcb_pkg::ST_GW_DOWN : ogcb_pkg::ST_RISK;
                        fail_ff <= fail_inc;
                        if (fail_inc >= threshold_ff) begin
                           circ = ogcb_pkg::CIRC_OPEN;
                           opened_ff <= req_ff.now_ns;
                        end
                     end else if (!free_ff) begin
                        rsp_ff.status <= ogcb_pkg::ST_FULL;
                     end else begin
                        if (circ == ogcb_pkg::CIRC_HALF) probe_ff <= 1'b1;
                        valid_ff[free_idx_ff] <= 1'b1;
                        rsp_ff.venue_ref <= next_vid_ff;
                        rsp_ff.echo_price <= req_ff.price;
                        rsp_ff.echo_quantity <= req_ff.quantity;
                        state_ff <= S_WRITE;
                     end
                     circuit_ff <= circ;
                  end
               end
            end
            S_WRITE: begin
               // memories take the new entry this cycle
               next_vid_ff <= next_vid_ff + 64'd1;
               state_ff <= S_DONE;
            end
            S_DONE: begin
               // gateway and halt writes land here, submit/ack already applied
               if (req_ff.op == ogcb_pkg::OP_GW) begin
                  gw_ff <= req_ff.new_gateway_state;
                  rsp_ff.gateway_now <= req_ff.new_gateway_state;
                  rsp_ff.circuit_now <=
                     (req_ff.new_gateway_state == ogcb_pkg::GW_READY) ?
                     ogcb_pkg::CIRC_CLOSED : circuit_ff;
                  if (req_ff.new_gateway_state == ogcb_pkg::GW_READY) begin
                     circuit_ff <= ogcb_pkg::CIRC_CLOSED;
                     fail_ff <= '0;
                     opened_ff <= '0;
                  end
               end else if (req_ff.op == ogcb_pkg::OP_HALT) begin
                  halted_ff <= req_ff.halt_flag;
                  rsp_ff.circuit_now <= circuit_ff;
                  if (req_ff.halt_flag) begin
                     gw_ff <= ogcb_pkg::GW_HALTED;
                     rsp_ff.gateway_now <= ogcb_pkg::GW_HALTED;
                  end else if (gw_ff == ogcb_pkg::GW_HALTED) begin
                     gw_ff <= ogcb_pkg::GW_READY;
                     rsp_ff.gateway_now <= ogcb_pkg::GW_READY;
                  end else begin
                     rsp_ff.gateway_now <= gw_ff;
                  end
               end else begin
                  rsp_ff.circuit_now <= circuit_ff;
                  rsp_ff.gateway_now <= gw_ff;
               end
               rsp_valid <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
